// ----- rtl/opm_pkg.sv -----
package opm_pkg;

  localparam int unsigned ROW_MAX = 64;
  localparam int unsigned COL_MAX = 64;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FRAC_W  = 16;

  localparam int unsigned ROW_AW  = $clog2(ROW_MAX);
  localparam int unsigned COL_AW  = $clog2(COL_MAX);
  localparam int unsigned ACC_AW  = ROW_AW + COL_AW;

  localparam int unsigned DIM_W   = 7;
  localparam int unsigned PASS_W  = 13;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned CFG_AW  = 2;

  localparam logic [CFG_AW-1:0] CFG_ROWS   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_COLS   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_PASSES = 2'd2;

  typedef enum logic [1:0] {
    FUNC_B    = 2'd0,
    FUNC_A    = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef struct packed {
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    logic [PASS_W-1:0] passes;
  } cfg_t;

  typedef struct packed {
    func_e             func;
    logic [WORD_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bstat_t;

endpackage

// ----- rtl/outer_product_matrix_multiply.sv -----
// An A element takes one MAC per column through a single multiplier and the
// accumulator RAM port. A readout word goes through the 13-step index divider
// after dequeue. Input passes a 2-entry queue first. Reset is asynchronous,
// active low; after reset and after the final readout word the 4096-word store
// is cleared, one word a cycle, with input stalled. Config registers reset to 1.
module outer_product_matrix_multiply (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [opm_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [opm_pkg::PASS_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  func_i,
  input  logic [opm_pkg::WORD_W-1:0]  data_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [opm_pkg::WORD_W-1:0]  result_word_o,
  output logic                        last_item_o
);
  import opm_pkg::*;

  cfg_t   cfg_q;
  qhead_t head;
  bstat_t bstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows   <= DIM_W'(1);
      cfg_q.cols   <= DIM_W'(1);
      cfg_q.passes <= PASS_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS:   cfg_q.rows   <= cfg_data_i[DIM_W-1:0];
        CFG_COLS:   cfg_q.cols   <= cfg_data_i[DIM_W-1:0];
        CFG_PASSES: cfg_q.passes <= cfg_data_i;
        default: ;
      endcase
    end
  end

  opm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .data_word_i (data_word_i),
    .bstat_i     (bstat),
    .head_o      (head)
  );

  opm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .bstat_o       (bstat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_word_o (result_word_o),
    .last_item_o   (last_item_o)
  );

  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.clearing |-> in_stall_o)
    else $error("input taken during store clear");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.pop |-> head.valid)
    else $error("queue popped while empty");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && last_item_o |-> bstat.clearing)
    else $error("final readout word without store clear");

endmodule

// ----- rtl/opm_front.sv -----
module opm_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [opm_pkg::WORD_W-1:0] data_word_i,
  input  opm_pkg::bstat_t       bstat_i,
  output opm_pkg::qhead_t       head_o
);
  import opm_pkg::*;

  item_t      fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  logic       full;

  assign full       = (cnt_q == 2'd2);
  assign in_stall_o = full | bstat_i.clearing;
  // func 3 means nothing: dropped here
  assign push = in_valid_i & ~in_stall_o & (func_i != FUNC_NONE);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].func <= func_e'(func_i);
      fifo_q[wr_ptr_q].data <= data_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (bstat_i.pop) rd_ptr_q <= ~rd_ptr_q;
      case ({push, bstat_i.pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/opm_div.sv -----
module opm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [opm_pkg::IDX_W-1:0] dividend_i,
  input  logic [opm_pkg::DIM_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [opm_pkg::IDX_W-1:0] quot_o,
  output logic [opm_pkg::DIM_W-1:0] rem_o
);
  import opm_pkg::*;

  localparam int unsigned CNT_W = $clog2(IDX_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [IDX_W-1:0] quo_q;
  logic [DIM_W-1:0] rem_q, div_q;
  logic [DIM_W+1:0] sub;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign sub = {1'b0, rem_q, quo_q[IDX_W-1]} - {2'b00, div_q};
  assign ge  = ~sub[DIM_W+1];

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(IDX_W);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        quo_q <= {quo_q[IDX_W-2:0], ge};
        rem_q <= ge ? sub[DIM_W-1:0] : {rem_q[DIM_W-2:0], quo_q[IDX_W-1]};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/opm_back.sv -----
module opm_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  opm_pkg::cfg_t              cfg_i,
  input  opm_pkg::qhead_t            head_i,
  output opm_pkg::bstat_t            bstat_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [opm_pkg::WORD_W-1:0] result_word_o,
  output logic                       last_item_o
);
  import opm_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MAC, ST_DIV, ST_READ, ST_LOAD
  } state_e;

  state_e            state_q;
  logic [DIM_W-1:0]  b_idx_q, row_idx_q;
  logic [PASS_W-1:0] pass_idx_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [ACC_AW-1:0] clr_q;
  logic [WORD_W-1:0] a_q;
  logic [COL_AW-1:0] iss_q;
  logic              iss_on_q, v1_q, v2_q;
  logic [ACC_AW-1:0] a1_q, a2_q;
  logic [WORD_W-1:0] prod_q, acc2_q;
  logic              last_q, in_rng_q;
  logic              out_valid_q, out_last_q;
  logic [WORD_W-1:0] out_word_q;

  logic [WORD_W-1:0] acc_mem [ROW_MAX*COL_MAX];
  logic [WORD_W-1:0] b_mem [COL_MAX];
  logic [WORD_W-1:0] acc_rd_q, b_rd_q;

  logic [DIM_W-1:0]    rows_eff, cols_eff;
  logic [PASS_W-1:0]   passes_eff;
  logic [2*DIM_W-1:0]  total;
  logic                last_d;
  logic                pop, a_ok, iss_last;
  logic                acc_we, b_we;
  logic [ACC_AW-1:0]   acc_wa, acc_ra;
  logic [WORD_W-1:0]   acc_wd;
  logic signed [2*WORD_W-1:0] prod_full;
  logic                div_start, div_done;
  logic [IDX_W-1:0]    quot;
  logic [DIM_W-1:0]    rem;
  logic [DIM_W-1:0]    row_nx;

  always_comb begin
    if (cfg_i.rows == '0)                    rows_eff = DIM_W'(1);
    else if (cfg_i.rows > DIM_W'(ROW_MAX))   rows_eff = DIM_W'(ROW_MAX);
    else                                     rows_eff = cfg_i.rows;
    if (cfg_i.cols == '0)                    cols_eff = DIM_W'(1);
    else if (cfg_i.cols > DIM_W'(COL_MAX))   cols_eff = DIM_W'(COL_MAX);
    else                                     cols_eff = cfg_i.cols;
    passes_eff = (cfg_i.passes == '0) ? PASS_W'(1) : cfg_i.passes;
  end

  assign total  = rows_eff * cols_eff;
  assign last_d = ({1'b0, rd_idx_q} + (IDX_W+1)'(1)) >= (IDX_W+1)'(total);

  assign pop = (state_q == ST_IDLE) & head_i.valid &
               ~((head_i.item.func == FUNC_READ) & out_valid_q);
  assign a_ok = (b_idx_q >= cols_eff) & (pass_idx_q < passes_eff) &
                (row_idx_q < DIM_W'(ROW_MAX));
  assign iss_last = ({1'b0, iss_q} == (cols_eff - DIM_W'(1)));
  assign row_nx   = row_idx_q + DIM_W'(1);

  assign b_we      = pop & (head_i.item.func == FUNC_B) & (b_idx_q < cols_eff);
  assign div_start = pop & (head_i.item.func == FUNC_READ);

  assign prod_full = $signed(a_q) * $signed(b_rd_q);

  assign acc_we = (state_q == ST_CLEAR) | v2_q;
  assign acc_wa = (state_q == ST_CLEAR) ? clr_q : a2_q;
  assign acc_wd = (state_q == ST_CLEAR) ? '0 : acc2_q + prod_q;
  assign acc_ra = (state_q == ST_READ) ? {quot[ROW_AW-1:0], rem[COL_AW-1:0]}
                                       : {row_idx_q[ROW_AW-1:0], iss_q};

  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd_q <= acc_mem[acc_ra];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) b_mem[b_idx_q[COL_AW-1:0]] <= head_i.item.data;
    b_rd_q <= b_mem[iss_q];
  end

  opm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_idx_q),
    .divisor_i  (cols_eff),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      b_idx_q     <= '0;
      row_idx_q   <= '0;
      pass_idx_q  <= '0;
      rd_idx_q    <= '0;
      clr_q       <= '0;
      a_q         <= '0;
      iss_q       <= '0;
      iss_on_q    <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      a1_q        <= '0;
      a2_q        <= '0;
      prod_q      <= '0;
      acc2_q      <= '0;
      last_q      <= 1'b0;
      in_rng_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_word_q  <= '0;
    end else begin
      // multiply-accumulate pipe: read, multiply, add and write back
      v1_q   <= (state_q == ST_MAC) & iss_on_q;
      a1_q   <= {row_idx_q[ROW_AW-1:0], iss_q};
      v2_q   <= v1_q;
      a2_q   <= a1_q;
      prod_q <= prod_full[FRAC_W+WORD_W-1:FRAC_W];
      acc2_q <= acc_rd_q;

      if (out_valid_q & ~out_stall_i) out_valid_q <= 1'b0;

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ACC_AW'(1);
          if (clr_q == '1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (pop) begin
            case (head_i.item.func)
              FUNC_B: begin
                if (b_we) b_idx_q <= b_idx_q + DIM_W'(1);
              end
              FUNC_A: begin
                if (a_ok) begin
                  a_q      <= head_i.item.data;
                  iss_q    <= '0;
                  iss_on_q <= 1'b1;
                  state_q  <= ST_MAC;
                end
              end
              FUNC_READ: begin
                last_q  <= last_d;
                state_q <= ST_DIV;
              end
              default: ;
            endcase
          end
        end
        ST_MAC: begin
          if (iss_on_q) begin
            if (iss_last) iss_on_q <= 1'b0;
            else          iss_q <= iss_q + COL_AW'(1);
          end else if (~v1_q & ~v2_q) begin
            state_q <= ST_IDLE;
            if (row_nx >= rows_eff) begin
              row_idx_q  <= '0;
              b_idx_q    <= '0;
              pass_idx_q <= pass_idx_q + PASS_W'(1);
            end else begin
              row_idx_q <= row_nx;
            end
          end
        end
        ST_DIV: begin
          if (div_done) state_q <= ST_READ;
        end
        ST_READ: begin
          in_rng_q <= (quot[IDX_W-1:ROW_AW] == '0);
          state_q  <= ST_LOAD;
        end
        ST_LOAD: begin
          out_valid_q <= 1'b1;
          out_word_q  <= in_rng_q ? acc_rd_q : '0;
          out_last_q  <= last_q;
          if (last_q) begin
            b_idx_q    <= '0;
            row_idx_q  <= '0;
            pass_idx_q <= '0;
            rd_idx_q   <= '0;
            clr_q      <= '0;
            state_q    <= ST_CLEAR;
          end else begin
            rd_idx_q <= rd_idx_q + IDX_W'(1);
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign bstat_o.pop      = pop;
  assign bstat_o.clearing = (state_q == ST_CLEAR);

  assign out_valid_o   = out_valid_q;
  assign result_word_o = out_word_q;
  assign last_item_o   = out_last_q;

endmodule
